@@ rtl/tdkc_pkg.sv @@
// Package with shared constants and types for the tagged digit key counter.
`timescale 1ns / 1ps
package tdkc_pkg;
   localparam logic [7:0] DELIM_RESET = 8'd59;
   localparam logic [7:0] TAG_RESET   = 8'd83;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   localparam int DEF_MAX_DIGITS    = 10;
   localparam int DEF_TABLE_ENTRIES = 1024;
   localparam int DEF_COUNT_BITS    = 32;

   localparam int KEY_OUT_BITS   = 40;
   localparam int LEN_OUT_BITS   = 4;
   localparam int COUNT_OUT_BITS = 32;
   localparam int MATCH_BITS     = 32;
   localparam int UNIQUE_BITS    = 11;

   localparam logic [1:0] PH_NONE   = 2'd0;
   localparam logic [1:0] PH_DELIM  = 2'd1;
   localparam logic [1:0] PH_TAG    = 2'd2;
   localparam logic [1:0] PH_GATHER = 2'd3;

   localparam logic [7:0] CSR_DELIM = 8'd0;
   localparam logic [7:0] CSR_TAG   = 8'd1;

   typedef struct packed {
      logic [COUNT_OUT_BITS-1:0] count;
      logic                      new_key;
      logic                      table_full;
      logic [UNIQUE_BITS-1:0]    unique_keys;
   } result_type;
endpackage

@@ rtl/tdkc_if.sv @@
// Interfaces for the request, response and register write channels.
`timescale 1ns / 1ps
interface tdkc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       end_of_stream;
   modport source (output valid, byte_value, end_of_stream, input ready);
   modport sink (input valid, byte_value, end_of_stream, output ready);
endinterface

interface tdkc_rsp_if;
   logic        valid;
   logic        ready;
   logic [39:0] key_digits;
   logic [3:0]  key_length;
   logic [31:0] occurrence_count;
   logic        new_key;
   logic        table_full;
   logic [31:0] total_matches;
   logic [10:0] unique_keys;
   modport source (output valid, key_digits, key_length, occurrence_count, new_key,
                   table_full, total_matches, unique_keys, input ready);
   modport sink (input valid, key_digits, key_length, occurrence_count, new_key,
                 table_full, total_matches, unique_keys, output ready);
endinterface

interface tdkc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/tagged_digit_key_counter_top.sv @@
// Top level of the tagged digit key counter: pattern scanner, digit chain and key table.
//
//   channel  role  when it moves
//   req_if   in    one byte or end of stream per request
//   rsp_if   out   one result for each ended non-empty key
//   csr_if   in    register write, index 0 delimiter, 1 tag
//
// An ended key holds the key table, and with it new requests, while the table searches
// its filled entries one at a time through T_READ and T_CMP, until a hit or until all
// filled entries miss and the key is inserted or dropped in T_INSERT; the table memory
// has one write port and one read port.
// Reset is synchronous and empties the table at once through its fill count.
// A result waiting in the table holds the table, and so new requests, until the output register is free.
`timescale 1ns / 1ps
module tagged_digit_key_counter_top
   import tdkc_pkg::*;
#(
   parameter int MAX_DIGITS    = DEF_MAX_DIGITS,
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
   input logic       clock,
   input logic       reset,
   tdkc_req_if.sink  req_if,
   tdkc_rsp_if.source rsp_if,
   tdkc_csr_if.sink  csr_if
);
   localparam int KEY_W = 4 * MAX_DIGITS;
   localparam int LEN_W = $clog2(MAX_DIGITS + 1);

   logic [7:0]       delim_ff, tag_ff;
   logic [1:0]       phase_ff, phase_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [KEY_W-1:0] hold_key_ff;
   logic [LEN_W-1:0] hold_len_ff;
   logic [MATCH_BITS-1:0] match_ff;
   logic             rsp_valid_ff;
   logic [39:0]      rsp_key_ff;
   logic [3:0]       rsp_len_ff;
   logic [31:0]      rsp_matches_ff;
   result_type       rsp_res_ff;

   logic             req_fire, is_delim, is_tag, is_digit, ends, append, clear_chain;
   logic             tbl_start, tbl_busy, tbl_valid, tbl_ready;
   result_type       tbl_res;
   logic [KEY_W-1:0] pend_digits;
   logic [63:0]      key_wide;
   logic [7:0]       len_wide;
   logic [7:0]       digit_val;

   assign req_fire  = req_if.valid && req_if.ready;
   assign req_if.ready = !tbl_busy;
   assign csr_if.ready = 1'b1;
   assign is_delim  = (req_if.byte_value == delim_ff);
   assign is_tag    = (req_if.byte_value == tag_ff);
   assign is_digit  = (req_if.byte_value >= CHAR_ZERO) && (req_if.byte_value <= CHAR_NINE);
   assign ends      = req_if.end_of_stream ||
                      (!is_delim && !is_tag && !(phase_ff == PH_GATHER && is_digit));
   assign append    = req_fire && !ends && !is_delim && !is_tag &&
                      (len_ff != LEN_W'(MAX_DIGITS));
   assign clear_chain = req_fire && ends;
   assign tbl_start = clear_chain && (len_ff != '0);
   assign digit_val = req_if.byte_value - CHAR_ZERO;

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      if (req_fire) begin
         if (ends) begin
            phase_in = PH_NONE;
            len_in   = '0;
         end else if (is_delim) begin
            unique case (phase_ff)
               PH_NONE: phase_in = PH_DELIM;
               PH_TAG:  phase_in = PH_GATHER;
               default: phase_in = PH_NONE;
            endcase
         end else if (is_tag) begin
            phase_in = (phase_ff == PH_DELIM) ? PH_TAG : PH_NONE;
         end else if (append) begin
            len_in = len_ff + 1'b1;
         end
      end
   end

   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      logic [3:0] from_prev;
      if (i == 0) begin : g_first
         assign from_prev = digit_val[3:0];
      end else begin : g_rest
         assign from_prev = pend_digits[4*(i-1) +: 4];
      end
      tdkc_digit_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .clear      (clear_chain),
         .shift      (append),
         .nibble_in  (from_prev),
         .nibble_out (pend_digits[4*i +: 4])
      );
   end

   tdkc_table #(
      .ENTRIES    (TABLE_ENTRIES),
      .KEY_W      (KEY_W),
      .LEN_W      (LEN_W),
      .COUNT_BITS (COUNT_BITS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .start     (tbl_start),
      .key       (hold_key_ff),
      .key_len   (hold_len_ff),
      .busy      (tbl_busy),
      .res_valid (tbl_valid),
      .res_ready (tbl_ready),
      .res       (tbl_res)
   );

   assign tbl_ready = !rsp_valid_ff || rsp_if.ready;
   assign key_wide  = 64'(hold_key_ff);
   assign len_wide  = 8'(hold_len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff     <= DELIM_RESET;
         tag_ff       <= TAG_RESET;
         phase_ff     <= PH_NONE;
         len_ff       <= '0;
         match_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_if.valid) begin
            unique case (csr_if.index)
               CSR_DELIM: delim_ff <= csr_if.data;
               CSR_TAG:   tag_ff   <= csr_if.data;
               default: ;
            endcase
         end
         phase_ff <= phase_in;
         len_ff   <= len_in;
         if (tbl_start && match_ff != '1) begin
            match_ff <= match_ff + 1'b1;
         end
         if (tbl_valid && tbl_ready) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (tbl_start) begin
         hold_key_ff <= pend_digits;
         hold_len_ff <= len_ff;
      end
      if (tbl_valid && tbl_ready) begin
         rsp_key_ff     <= key_wide[39:0];
         rsp_len_ff     <= len_wide[3:0];
         rsp_matches_ff <= match_ff;
         rsp_res_ff     <= tbl_res;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.key_digits       = rsp_key_ff;
   assign rsp_if.key_length       = rsp_len_ff;
   assign rsp_if.occurrence_count = rsp_res_ff.count;
   assign rsp_if.new_key          = rsp_res_ff.new_key;
   assign rsp_if.table_full       = rsp_res_ff.table_full;
   assign rsp_if.total_matches    = rsp_matches_ff;
   assign rsp_if.unique_keys      = rsp_res_ff.unique_keys;

   assert property (@(posedge clock) disable iff (reset) tbl_start |-> !tbl_busy)
      else $error("Table search started while a search was running.");
   assert property (@(posedge clock) disable iff (reset) tbl_start |=> tbl_busy)
      else $error("Table did not take up a started search.");
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff |-> !(rsp_res_ff.new_key && rsp_res_ff.table_full))
      else $error("Result flags a key both inserted and dropped.");
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && rsp_res_ff.table_full) |-> (rsp_res_ff.count == '0))
      else $error("Dropped key reports a nonzero count.");
endmodule

@@ rtl/tdkc_digit_cell.sv @@
// One digit cell of the key shift chain, holding a single BCD nibble.
`timescale 1ns / 1ps
module tdkc_digit_cell
   import tdkc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       clear,
   input  logic       shift,
   input  logic [3:0] nibble_in,
   output logic [3:0] nibble_out
);
   logic [3:0] nibble_ff;
   logic [3:0] nibble_in_next;

   always_comb begin
      nibble_in_next = nibble_ff;
      if (clear) begin
         nibble_in_next = 4'd0;
      end else if (shift) begin
         nibble_in_next = nibble_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nibble_ff <= 4'd0;
      end else begin
         nibble_ff <= nibble_in_next;
      end
   end

   assign nibble_out = nibble_ff;
endmodule

@@ rtl/tdkc_table.sv @@
// Key table with a sequential search over the filled entries and insert at the end, or a drop when full.
`timescale 1ns / 1ps
module tdkc_table
   import tdkc_pkg::*;
#(
   parameter int ENTRIES    = DEF_TABLE_ENTRIES,
   parameter int KEY_W      = 4 * DEF_MAX_DIGITS,
   parameter int LEN_W      = 4,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] key,
   input  logic [LEN_W-1:0] key_len,
   output logic             busy,
   output logic             res_valid,
   input  logic             res_ready,
   output result_type       res
);
   localparam int ADDR_W = $clog2(ENTRIES);
   localparam int TOT_W  = $clog2(ENTRIES + 1);
   localparam int ENT_W  = KEY_W + LEN_W;

   localparam logic [2:0] T_IDLE   = 3'd0;
   localparam logic [2:0] T_READ   = 3'd1;
   localparam logic [2:0] T_CMP    = 3'd2;
   localparam logic [2:0] T_INSERT = 3'd3;
   localparam logic [2:0] T_DONE   = 3'd4;

   logic [ENT_W-1:0]      key_mem [ENTRIES];
   logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];
   logic [ENT_W-1:0]      rd_key_ff;
   logic [COUNT_BITS-1:0] rd_cnt_ff;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   result_type        res_ff, res_in;

   logic                  key_we, cnt_we;
   logic [ADDR_W-1:0]     wr_addr;
   logic [COUNT_BITS-1:0] wr_cnt;
   logic [COUNT_BITS-1:0] inc_cnt;
   logic [TOT_W-1:0]      idx_next;
   logic [63:0]           cnt_wide;
   logic [31:0]           tot_wide;

   always_comb begin
      inc_cnt  = (rd_cnt_ff == '1) ? rd_cnt_ff : rd_cnt_ff + 1'b1;
      idx_next = TOT_W'({1'b0, idx_ff}) + 1'b1;
      state_in = state_ff;
      idx_in   = idx_ff;
      total_in = total_ff;
      res_in   = res_ff;
      key_we   = 1'b0;
      cnt_we   = 1'b0;
      wr_addr  = idx_ff;
      wr_cnt   = inc_cnt;
      cnt_wide = 64'(inc_cnt);
      tot_wide = 32'(total_ff);
      unique case (state_ff)
         T_IDLE: begin
            if (start) begin
               idx_in   = '0;
               state_in = (total_ff == '0) ? T_INSERT : T_READ;
            end
         end
         T_READ: begin
            state_in = T_CMP;
         end
         T_CMP: begin
            if (rd_key_ff == {key_len, key}) begin
               cnt_we             = 1'b1;
               res_in.count       = cnt_wide[COUNT_OUT_BITS-1:0];
               res_in.new_key     = 1'b0;
               res_in.table_full  = 1'b0;
               res_in.unique_keys = tot_wide[UNIQUE_BITS-1:0];
               state_in           = T_DONE;
            end else if (idx_next == total_ff) begin
               state_in = T_INSERT;
            end else begin
               idx_in   = idx_next[ADDR_W-1:0];
               state_in = T_READ;
            end
         end
         T_INSERT: begin
            wr_addr = total_ff[ADDR_W-1:0];
            wr_cnt  = COUNT_BITS'(1);
            if (total_ff != TOT_W'(ENTRIES)) begin
               key_we             = 1'b1;
               cnt_we             = 1'b1;
               total_in           = total_ff + 1'b1;
               tot_wide           = 32'(total_in);
               res_in.count       = COUNT_OUT_BITS'(1);
               res_in.new_key     = 1'b1;
               res_in.table_full  = 1'b0;
            end else begin
               res_in.count       = '0;
               res_in.new_key     = 1'b0;
               res_in.table_full  = 1'b1;
            end
            res_in.unique_keys = tot_wide[UNIQUE_BITS-1:0];
            state_in           = T_DONE;
         end
         T_DONE: begin
            if (res_ready) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= {key_len, key};
      end
      if (cnt_we) begin
         cnt_mem[wr_addr] <= wr_cnt;
      end
      rd_key_ff <= key_mem[idx_ff];
      rd_cnt_ff <= cnt_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         idx_ff   <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         total_ff <= total_in;
      end
      res_ff <= res_in;
   end

   assign busy      = (state_ff != T_IDLE);
   assign res_valid = (state_ff == T_DONE);
   assign res       = res_ff;
endmodule
